### design/sirt_pkg.sv
`timescale 1ns / 1ps

package sirt_pkg;

	localparam int DEF_SLOTS_PER_TABLE = 16;
	localparam int DEF_STEP_RANGE      = 1024;
	localparam int DEF_TRACK_COUNT     = 8;
	localparam int DEF_CHANNELS        = 5;
	localparam int NOTE_W              = 8;

	typedef enum logic [1:0] {
		REQ_PLACE  = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_RESIZE = 2'd2,
		REQ_FIND   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD       = 2'd1,
		ST_NO_ROOM   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_READ,
		S_PROC,
		S_SPLIT,
		S_INSERT,
		S_DRAIN,
		S_UNLOAD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic unload;
	} cell_ctl_t;

endpackage

### design/sorted_interval_region_table_top.sv
`timescale 1ns / 1ps

// Channel    | Signals                                               | Handshake
// -----------+-------------------------------------------------------+----------------------
// request    | req_type track channel region_start region_length     | start & !busy
//            | note_value entry_index probe_tick                     |
// result     | status result_index entry_count                       | done, one cycle
//
// One item at a time. A bad track or channel goes straight to the response state, with done in the
// cycle after acceptance. Otherwise the item reads the table fill, streams the table
// out of the entry memory through a read state and a process state per entry (and a
// split state for the one entry that is split), and for a place, remove or resize that
// the fill state does not turn back lets the cell row settle in the drain state and
// writes the row back at one entry a cycle. A find skips the drain and write-back.
// Reset clears the state machine, the cell row and the per-table valid bits; a
// table whose valid bit is clear reads as empty, so no clearing pass is needed.
// The receiver cannot stall: done is high for exactly one cycle per item.
module sorted_interval_region_table_top import sirt_pkg::*; #(
	parameter int SLOTS_PER_TABLE = DEF_SLOTS_PER_TABLE,
	parameter int STEP_RANGE      = DEF_STEP_RANGE,
	parameter int TRACK_COUNT     = DEF_TRACK_COUNT,
	parameter int CHANNELS        = DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         req_type,
	input  logic [2:0]         track,
	input  logic [2:0]         channel,
	input  logic signed [15:0] region_start,
	input  logic signed [15:0] region_length,
	input  logic [7:0]         note_value,
	input  logic [7:0]         entry_index,
	input  logic [15:0]        probe_tick,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status,
	output logic [3:0]         result_index,
	output logic [4:0]         entry_count
);

	localparam int TABLES = TRACK_COUNT * CHANNELS;
	localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int DEPTH  = TABLES * SLOTS_PER_TABLE;
	localparam int RA_W   = $clog2(DEPTH);
	localparam int POS_W  = $clog2(STEP_RANGE);
	localparam int SIZE_W = $clog2(STEP_RANGE + 1);
	localparam int E_W    = SIZE_W + 1;
	localparam int ENT_W  = POS_W + SIZE_W + NOTE_W;
	localparam int CNT_W  = $clog2(SLOTS_PER_TABLE + 1);

	state_t state_q, state_d;

	// request registers
	req_t              req_q;
	logic [7:0]        idx_q;
	logic [15:0]       tick_q;
	logic [NOTE_W-1:0] note_q;
	logic [POS_W-1:0]  lo_q;
	logic [SIZE_W-1:0] hi_q;
	logic              empty_q;
	logic              carve_q;
	logic [TBL_W-1:0]  tbl_q;
	logic [RA_W-1:0]   base_q;

	// walk registers
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  out_q;
	logic [CNT_W-1:0]  rix_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  wr_q;
	logic              found_q;
	logic [NOTE_W-1:0] keep_q;
	logic [ENT_W-1:0]  right_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;
	logic              fvld_q [TABLES];

	// accept-side decode
	logic              accept;
	logic              bad_tc;
	logic [15:0]       s_clamp;
	logic [15:0]       l_clamp;
	logic [16:0]       sum17;
	logic [TBL_W-1:0]  tbl_d;
	logic [POS_W-1:0]  lo_d;
	logic [SIZE_W-1:0] hi_d;
	logic              empty_d;

	// memories
	logic [CNT_W-1:0]  fill_rdata;
	logic              fill_we;
	logic [CNT_W-1:0]  fill_n;
	logic              reg_we;
	logic [RA_W-1:0]   reg_waddr;
	logic [RA_W-1:0]   reg_raddr;
	logic [ENT_W-1:0]  reg_rdata;

	// entry under test
	logic [POS_W-1:0]  e_first;
	logic [SIZE_W-1:0] e_size;
	logic [NOTE_W-1:0] e_note;
	logic [E_W-1:0]    e_end;
	logic              outside;
	logic              has_left;
	logic              has_right;
	logic              skip;
	logic              covers;
	logic              room;
	logic [ENT_W-1:0]  left_e;
	logic [ENT_W-1:0]  right_e;
	logic [ENT_W-1:0]  new_e;

	// cell row
	cell_ctl_t         ctl;
	logic              push_req;
	logic              push_v;
	logic [ENT_W-1:0]  push_e;
	logic              split_d;
	logic              cv [SLOTS_PER_TABLE+1];
	logic [ENT_W-1:0]  ce [SLOTS_PER_TABLE+1];
	logic              hv [SLOTS_PER_TABLE+1];
	logic [ENT_W-1:0]  he [SLOTS_PER_TABLE+1];

	logic [31:0]       rix_w;
	logic [31:0]       count_w;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign bad_tc = (32'(track) >= TRACK_COUNT) || (32'(channel) >= CHANNELS);

	// clamp the span: start at least 0, length at least 1, end no later than the range
	assign s_clamp = region_start[15] ? 16'd0 : $unsigned(region_start);
	assign l_clamp = (region_length < 16'sd1) ? 16'd1 : $unsigned(region_length);
	assign sum17   = {1'b0, s_clamp} + {1'b0, l_clamp};
	assign empty_d = (32'(s_clamp) >= STEP_RANGE);
	assign lo_d    = s_clamp[POS_W-1:0];
	assign hi_d    = (32'(sum17) > STEP_RANGE) ? SIZE_W'(STEP_RANGE) : SIZE_W'(sum17);
	assign tbl_d   = TBL_W'(32'(track) * CHANNELS + 32'(channel));

	sirt_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TABLES)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (tbl_q),
		.wdata (count_q),
		.raddr (tbl_d),
		.rdata (fill_rdata)
	);

	sirt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_region_ram (
		.clk   (clk),
		.we    (reg_we),
		.waddr (reg_waddr),
		.wdata (he[0]),
		.raddr (reg_raddr),
		.rdata (reg_rdata)
	);

	assign fill_n    = fvld_q[tbl_q] ? fill_rdata : '0;
	assign reg_raddr = RA_W'(32'(base_q) + 32'(i_q));
	assign reg_waddr = RA_W'(32'(base_q) + 32'(wr_q));

	// carve the stored entry against [lo, hi)
	assign e_first   = reg_rdata[ENT_W-1 -: POS_W];
	assign e_size    = reg_rdata[NOTE_W +: SIZE_W];
	assign e_note    = reg_rdata[NOTE_W-1:0];
	assign e_end     = E_W'(e_first) + E_W'(e_size);
	assign outside   = (e_end <= E_W'(lo_q)) || (E_W'(e_first) >= E_W'(hi_q));
	assign has_left  = (e_first < lo_q);
	assign has_right = (e_end > E_W'(hi_q));
	assign left_e    = {e_first, SIZE_W'(lo_q) - SIZE_W'(e_first), e_note};
	assign right_e   = {POS_W'(hi_q), SIZE_W'(e_end - E_W'(hi_q)), e_note};
	assign new_e     = {lo_q, hi_q - SIZE_W'(lo_q), (req_q == REQ_RESIZE) ? keep_q : note_q};
	assign skip      = ((req_q == REQ_REMOVE) || (req_q == REQ_RESIZE))
			&& (32'(i_q) == 32'(idx_q));
	assign covers    = ({1'b0, tick_q} >= 17'(e_first)) && ({1'b0, tick_q} < 17'(e_end));
	assign room      = (32'(out_q) < SLOTS_PER_TABLE);
	assign push_v    = push_req && room;

	// next state and row control
	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		push_req   = 1'b0;
		push_e     = reg_rdata;
		split_d    = 1'b0;
		fill_we    = 1'b0;
		reg_we     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = bad_tc ? S_RESP : S_FILL;
				end
			end
			S_FILL: begin
				ctl.clear = 1'b1;
				if (((req_q == REQ_REMOVE) || (req_q == REQ_RESIZE))
						&& (32'(idx_q) >= 32'(fill_n))) begin
					state_d = S_RESP;
				end else if ((req_q == REQ_PLACE) && empty_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (i_q == n_q) begin
					if (req_q == REQ_FIND) begin
						state_d = S_RESP;
					end else if (carve_q && room) begin
						state_d = S_INSERT;
					end else begin
						state_d = S_DRAIN;
					end
				end else begin
					state_d = S_PROC;
				end
			end
			S_PROC: begin
				state_d = S_READ;
				if (req_q != REQ_FIND && !skip) begin
					if (!carve_q || outside) begin
						push_req = 1'b1;
					end else if (has_left) begin
						push_req = 1'b1;
						push_e   = left_e;
						if (has_right) begin
							split_d = 1'b1;
							state_d = S_SPLIT;
						end
					end else if (has_right) begin
						push_req = 1'b1;
						push_e   = right_e;
					end
				end
			end
			S_SPLIT: begin
				push_req = 1'b1;
				push_e   = right_q;
				state_d  = S_READ;
			end
			S_INSERT: begin
				push_req = 1'b1;
				push_e   = new_e;
				state_d  = S_DRAIN;
			end
			S_DRAIN: begin
				fill_we = (cnt_q == '0);
				if (32'(cnt_q) == SLOTS_PER_TABLE - 1) begin
					state_d = S_UNLOAD;
				end
			end
			S_UNLOAD: begin
				if (wr_q == count_q) begin
					state_d = S_RESP;
				end else begin
					ctl.unload = 1'b1;
					reg_we     = 1'b1;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-table valid bits: a table never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TABLES; t++) begin
				fvld_q[t] <= 1'b0;
			end
		end else if (fill_we) begin
			fvld_q[tbl_q] <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q    <= req_t'(req_type);
					idx_q    <= entry_index;
					tick_q   <= probe_tick;
					note_q   <= note_value;
					lo_q     <= lo_d;
					hi_q     <= hi_d;
					empty_q  <= empty_d;
					carve_q  <= ((req_t'(req_type) == REQ_PLACE)
							|| (req_t'(req_type) == REQ_RESIZE)) && !empty_d;
					tbl_q    <= tbl_d;
					rix_q    <= '0;
					status_q <= ST_BAD;
					count_q  <= '0;
				end
			end
			S_FILL: begin
				n_q      <= fill_n;
				i_q      <= '0;
				out_q    <= '0;
				found_q  <= 1'b0;
				base_q   <= RA_W'(32'(tbl_q) * SLOTS_PER_TABLE);
				count_q  <= fill_n;
				// these stand unless the walk overrides them
				status_q <= (req_q == REQ_PLACE) ? ST_NO_ROOM : ST_BAD;
			end
			S_READ: begin
				if (i_q == n_q) begin
					cnt_q <= '0;
					wr_q  <= '0;
					if (req_q == REQ_FIND) begin
						status_q <= found_q ? ST_OK : ST_NOT_FOUND;
						count_q  <= n_q;
					end else if (carve_q && room) begin
						status_q <= ST_OK;
						count_q  <= out_q + 1'b1;
					end else begin
						status_q <= (req_q == REQ_REMOVE) ? ST_OK : ST_NO_ROOM;
						count_q  <= out_q;
					end
				end
			end
			S_PROC: begin
				i_q <= i_q + 1'b1;
				if (skip) begin
					keep_q <= e_note;
				end
				if (req_q == REQ_FIND && !found_q && covers) begin
					found_q <= 1'b1;
					rix_q   <= i_q;
				end
				if (split_d) begin
					right_q <= right_e;
				end
			end
			S_DRAIN: begin
				cnt_q <= cnt_q + 1'b1;
			end
			S_UNLOAD: begin
				if (wr_q != count_q) begin
					wr_q <= wr_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		// count pieces as they enter the row; those left of the new span set its index
		if (push_v) begin
			out_q <= out_q + 1'b1;
			if (carve_q && (push_e[ENT_W-1 -: POS_W] < lo_q)) begin
				rix_q <= rix_q + 1'b1;
			end
		end
	end

	// cell row: pieces enter at cell 0 and sort themselves; unload shifts towards cell 0
	assign cv[0] = push_v;
	assign ce[0] = push_e;
	assign hv[SLOTS_PER_TABLE] = 1'b0;
	assign he[SLOTS_PER_TABLE] = '0;

	for (genvar k = 0; k < SLOTS_PER_TABLE; k++) begin : g_cell
		sirt_cell #(
			.POS_W  (POS_W),
			.SIZE_W (SIZE_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.in_v   (cv[k]),
			.in_e   (ce[k]),
			.nb_v   (hv[k+1]),
			.nb_e   (he[k+1]),
			.pass_v (cv[k+1]),
			.pass_e (ce[k+1]),
			.hold_v (hv[k]),
			.hold_e (he[k])
		);
	end

	// result
	assign rix_w        = 32'(rix_q);
	assign count_w      = 32'(count_q);
	assign done         = (state_q == S_RESP);
	assign status       = status_q;
	assign result_index = (status_q == ST_OK) ? rix_w[3:0] : 4'd0;
	assign entry_count  = count_w[4:0];

	// nothing falls off the end of the row
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!cv[SLOTS_PER_TABLE])
		else $error("cell row overflow");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe did not end the item");

	a_walk_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROC || state_q == S_SPLIT) |-> (32'(out_q) <= SLOTS_PER_TABLE))
		else $error("piece count beyond capacity");

	a_unload_real: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNLOAD && wr_q != count_q) |-> hv[0])
		else $error("write-back of an empty cell");

endmodule

### design/sirt_ram.sv
`timescale 1ns / 1ps

module sirt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/sirt_cell.sv
`timescale 1ns / 1ps

module sirt_cell import sirt_pkg::*; #(
	parameter int POS_W  = 10,
	parameter int SIZE_W = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cell_ctl_t                       ctl,
	input  logic                            in_v,
	input  logic [POS_W+SIZE_W+NOTE_W-1:0]  in_e,
	input  logic                            nb_v,
	input  logic [POS_W+SIZE_W+NOTE_W-1:0]  nb_e,
	output logic                            pass_v,
	output logic [POS_W+SIZE_W+NOTE_W-1:0]  pass_e,
	output logic                            hold_v,
	output logic [POS_W+SIZE_W+NOTE_W-1:0]  hold_e
);

	localparam int ENT_W = POS_W + SIZE_W + NOTE_W;

	logic             hold_v_q;
	logic             pass_v_q;
	logic [ENT_W-1:0] hold_q;
	logic [ENT_W-1:0] pass_q;
	logic             take;

	// keep the smaller start, pass the other one on
	assign take = !hold_v_q || (in_e[ENT_W-1 -: POS_W] < hold_q[ENT_W-1 -: POS_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			pass_v_q <= 1'b0;
		end else if (ctl.clear) begin
			hold_v_q <= 1'b0;
			pass_v_q <= 1'b0;
		end else if (ctl.unload) begin
			hold_v_q <= nb_v;
			pass_v_q <= 1'b0;
		end else if (in_v) begin
			if (take) begin
				hold_v_q <= 1'b1;
				pass_v_q <= hold_v_q;
			end else begin
				pass_v_q <= 1'b1;
			end
		end else begin
			pass_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear) begin
			if (ctl.unload) begin
				hold_q <= nb_e;
			end else if (in_v) begin
				if (take) begin
					hold_q <= in_e;
					pass_q <= hold_q;
				end else begin
					pass_q <= in_e;
				end
			end
		end
	end

	assign pass_v = pass_v_q;
	assign pass_e = pass_q;
	assign hold_v = hold_v_q;
	assign hold_e = hold_q;

endmodule
